### rtl/cpu_ex_pkg.sv
// Operation codes and status flag positions for the eight-bit CPU execute unit.
package cpu_ex_pkg;

  localparam int unsigned FUNC_W = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADC = 6'd0,  FN_SBC = 6'd1,  FN_AND = 6'd2,  FN_ORA = 6'd3,
    FN_EOR = 6'd4,  FN_ASL = 6'd5,  FN_LSR = 6'd6,  FN_ROL = 6'd7,
    FN_ROR = 6'd8,  FN_BIT = 6'd9,  FN_CMP = 6'd10, FN_CPX = 6'd11,
    FN_CPY = 6'd12, FN_INC = 6'd13, FN_DEC = 6'd14, FN_INX = 6'd15,
    FN_INY = 6'd16, FN_DEX = 6'd17, FN_DEY = 6'd18, FN_LDA = 6'd19,
    FN_LDX = 6'd20, FN_LDY = 6'd21, FN_STA = 6'd22, FN_STX = 6'd23,
    FN_STY = 6'd24, FN_TAX = 6'd25, FN_TAY = 6'd26, FN_TSX = 6'd27,
    FN_TXA = 6'd28, FN_TXS = 6'd29, FN_TYA = 6'd30, FN_CLC = 6'd31,
    FN_CLD = 6'd32, FN_CLI = 6'd33, FN_CLV = 6'd34, FN_SEC = 6'd35,
    FN_SED = 6'd36, FN_SEI = 6'd37, FN_PHA = 6'd38, FN_PHP = 6'd39,
    FN_PLA = 6'd40, FN_PLP = 6'd41, FN_BCC = 6'd42, FN_BCS = 6'd43,
    FN_BEQ = 6'd44, FN_BNE = 6'd45, FN_BMI = 6'd46, FN_BPL = 6'd47,
    FN_BVC = 6'd48, FN_BVS = 6'd49, FN_NOP = 6'd50
  } func_t;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;

endpackage

### rtl/eight_bit_cpu_execute_unit.sv
// Execute stage of an eight-bit CPU: register file, flag logic and result register.
//
// One instruction is taken per cycle; its result appears in the next cycle in
// the result register; a stalled result still lets the next transaction in as
// long as the result register is being emptied in the same cycle. A, X, Y, S
// and P update at the edge that accepts the instruction, so the following
// instruction sees them straight away. Arithmetic is binary only; the decimal
// flag is stored but has no effect on ADC or SBC. Codes above NOP act as NOP.
module eight_bit_cpu_execute_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [5:0]        func,
  input  logic [7:0]        operand,
  input  logic              accumulator_mode,
  input  logic [15:0]       next_pc,
  input  logic signed [7:0] branch_offset,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              write_enable,
  output logic [7:0]        write_data,
  output logic              use_stack_address,
  output logic [7:0]        stack_address,
  output logic              branch_taken,
  output logic [15:0]       branch_target,
  output logic              page_crossed,
  output logic [7:0]        flags_out,
  output logic [7:0]        accumulator_out
);

  logic [7:0] accumulator, index_x, index_y, stack_pointer, status_flags;
  logic [7:0] accumulator_next, index_x_next, index_y_next;
  logic [7:0] stack_pointer_next, status_flags_next;

  logic       we_c, use_sp_c, taken_c, crossed_c;
  logic [7:0] wd_c, sa_c;
  logic [15:0] target_c;

  logic [7:0] add_m, shift_src, shift_res, cmp_reg, logic_res;
  logic [8:0] add_sum, cmp_diff;
  logic [15:0] off_ext, target_sum;
  logic       branch_flag, branch_want;
  logic       accept;

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[cpu_ex_pkg::FLAG_Z] = (v == 8'h00);
    q[cpu_ex_pkg::FLAG_N] = v[7];
    return q;
  endfunction

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign add_m   = (func == cpu_ex_pkg::FN_SBC) ? ~operand : operand;
  assign add_sum = {1'b0, accumulator} + {1'b0, add_m} +
                   {8'h00, status_flags[cpu_ex_pkg::FLAG_C]};

  assign shift_src = accumulator_mode ? accumulator : operand;

  always_comb begin
    case (func)
      cpu_ex_pkg::FN_CPX: cmp_reg = index_x;
      cpu_ex_pkg::FN_CPY: cmp_reg = index_y;
      default:            cmp_reg = accumulator;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

  always_comb begin
    case (func)
      cpu_ex_pkg::FN_ORA: logic_res = accumulator | operand;
      cpu_ex_pkg::FN_EOR: logic_res = accumulator ^ operand;
      default:            logic_res = accumulator & operand;
    endcase
  end

  always_comb begin
    case (func)
      cpu_ex_pkg::FN_LSR: shift_res = {1'b0, shift_src[7:1]};
      cpu_ex_pkg::FN_ROL: shift_res = {shift_src[6:0], status_flags[cpu_ex_pkg::FLAG_C]};
      cpu_ex_pkg::FN_ROR: shift_res = {status_flags[cpu_ex_pkg::FLAG_C], shift_src[7:1]};
      default:            shift_res = {shift_src[6:0], 1'b0};
    endcase
  end

  assign off_ext    = {{8{branch_offset[7]}}, branch_offset};
  assign target_sum = next_pc + off_ext;

  always_comb begin
    case (func) inside
      cpu_ex_pkg::FN_BCC, cpu_ex_pkg::FN_BCS: branch_flag = status_flags[cpu_ex_pkg::FLAG_C];
      cpu_ex_pkg::FN_BEQ, cpu_ex_pkg::FN_BNE: branch_flag = status_flags[cpu_ex_pkg::FLAG_Z];
      cpu_ex_pkg::FN_BMI, cpu_ex_pkg::FN_BPL: branch_flag = status_flags[cpu_ex_pkg::FLAG_N];
      default:                                branch_flag = status_flags[cpu_ex_pkg::FLAG_V];
    endcase
  end
  assign branch_want = (func == cpu_ex_pkg::FN_BCS) || (func == cpu_ex_pkg::FN_BEQ) ||
                       (func == cpu_ex_pkg::FN_BMI) || (func == cpu_ex_pkg::FN_BVS);

  always_comb begin
    accumulator_next   = accumulator;
    index_x_next       = index_x;
    index_y_next       = index_y;
    stack_pointer_next = stack_pointer;
    status_flags_next  = status_flags;
    we_c      = 1'b0;
    wd_c      = 8'h00;
    use_sp_c  = 1'b0;
    sa_c      = 8'h00;
    taken_c   = 1'b0;
    target_c  = 16'h0000;
    crossed_c = 1'b0;
    unique case (func) inside
      cpu_ex_pkg::FN_ADC, cpu_ex_pkg::FN_SBC: begin
        accumulator_next = add_sum[7:0];
        status_flags_next = with_nz(status_flags, add_sum[7:0]);
        status_flags_next[cpu_ex_pkg::FLAG_C] = add_sum[8];
        status_flags_next[cpu_ex_pkg::FLAG_V] =
          ~(accumulator[7] ^ add_m[7]) & (accumulator[7] ^ add_sum[7]);
      end
      cpu_ex_pkg::FN_AND, cpu_ex_pkg::FN_ORA, cpu_ex_pkg::FN_EOR: begin
        accumulator_next  = logic_res;
        status_flags_next = with_nz(status_flags, logic_res);
      end
      cpu_ex_pkg::FN_ASL, cpu_ex_pkg::FN_LSR, cpu_ex_pkg::FN_ROL, cpu_ex_pkg::FN_ROR: begin
        status_flags_next = with_nz(status_flags, shift_res);
        status_flags_next[cpu_ex_pkg::FLAG_C] =
          ((func == cpu_ex_pkg::FN_ASL) || (func == cpu_ex_pkg::FN_ROL)) ?
          shift_src[7] : shift_src[0];
        if (accumulator_mode) begin
          accumulator_next = shift_res;
        end else begin
          we_c = 1'b1;
          wd_c = shift_res;
        end
      end
      cpu_ex_pkg::FN_BIT: begin
        status_flags_next[cpu_ex_pkg::FLAG_Z] = ((accumulator & operand) == 8'h00);
        status_flags_next[cpu_ex_pkg::FLAG_N] = operand[7];
        status_flags_next[cpu_ex_pkg::FLAG_V] = operand[6];
      end
      cpu_ex_pkg::FN_CMP, cpu_ex_pkg::FN_CPX, cpu_ex_pkg::FN_CPY: begin
        status_flags_next = with_nz(status_flags, cmp_diff[7:0]);
        status_flags_next[cpu_ex_pkg::FLAG_C] = ~cmp_diff[8];
      end
      cpu_ex_pkg::FN_INC: begin
        wd_c = operand + 8'h01;
        we_c = 1'b1;
        status_flags_next = with_nz(status_flags, operand + 8'h01);
      end
      cpu_ex_pkg::FN_DEC: begin
        wd_c = operand - 8'h01;
        we_c = 1'b1;
        status_flags_next = with_nz(status_flags, operand - 8'h01);
      end
      cpu_ex_pkg::FN_INX: begin
        index_x_next = index_x + 8'h01;
        status_flags_next = with_nz(status_flags, index_x + 8'h01);
      end
      cpu_ex_pkg::FN_INY: begin
        index_y_next = index_y + 8'h01;
        status_flags_next = with_nz(status_flags, index_y + 8'h01);
      end
      cpu_ex_pkg::FN_DEX: begin
        index_x_next = index_x - 8'h01;
        status_flags_next = with_nz(status_flags, index_x - 8'h01);
      end
      cpu_ex_pkg::FN_DEY: begin
        index_y_next = index_y - 8'h01;
        status_flags_next = with_nz(status_flags, index_y - 8'h01);
      end
      cpu_ex_pkg::FN_LDA: begin
        accumulator_next  = operand;
        status_flags_next = with_nz(status_flags, operand);
      end
      cpu_ex_pkg::FN_LDX: begin
        index_x_next      = operand;
        status_flags_next = with_nz(status_flags, operand);
      end
      cpu_ex_pkg::FN_LDY: begin
        index_y_next      = operand;
        status_flags_next = with_nz(status_flags, operand);
      end
      cpu_ex_pkg::FN_STA: begin
        we_c = 1'b1;
        wd_c = accumulator;
      end
      cpu_ex_pkg::FN_STX: begin
        we_c = 1'b1;
        wd_c = index_x;
      end
      cpu_ex_pkg::FN_STY: begin
        we_c = 1'b1;
        wd_c = index_y;
      end
      cpu_ex_pkg::FN_TAX: begin
        index_x_next      = accumulator;
        status_flags_next = with_nz(status_flags, accumulator);
      end
      cpu_ex_pkg::FN_TAY: begin
        index_y_next      = accumulator;
        status_flags_next = with_nz(status_flags, accumulator);
      end
      cpu_ex_pkg::FN_TSX: begin
        index_x_next      = stack_pointer;
        status_flags_next = with_nz(status_flags, stack_pointer);
      end
      cpu_ex_pkg::FN_TXA: begin
        accumulator_next  = index_x;
        status_flags_next = with_nz(status_flags, index_x);
      end
      cpu_ex_pkg::FN_TXS: stack_pointer_next = index_x;
      cpu_ex_pkg::FN_TYA: begin
        accumulator_next  = index_y;
        status_flags_next = with_nz(status_flags, index_y);
      end
      cpu_ex_pkg::FN_CLC: status_flags_next[cpu_ex_pkg::FLAG_C] = 1'b0;
      cpu_ex_pkg::FN_CLD: status_flags_next[cpu_ex_pkg::FLAG_D] = 1'b0;
      cpu_ex_pkg::FN_CLI: status_flags_next[cpu_ex_pkg::FLAG_I] = 1'b0;
      cpu_ex_pkg::FN_CLV: status_flags_next[cpu_ex_pkg::FLAG_V] = 1'b0;
      cpu_ex_pkg::FN_SEC: status_flags_next[cpu_ex_pkg::FLAG_C] = 1'b1;
      cpu_ex_pkg::FN_SED: status_flags_next[cpu_ex_pkg::FLAG_D] = 1'b1;
      cpu_ex_pkg::FN_SEI: status_flags_next[cpu_ex_pkg::FLAG_I] = 1'b1;
      cpu_ex_pkg::FN_PHA, cpu_ex_pkg::FN_PHP: begin
        we_c = 1'b1;
        if (func == cpu_ex_pkg::FN_PHA) begin
          wd_c = accumulator;
        end else begin
          wd_c = status_flags;
          wd_c[cpu_ex_pkg::FLAG_B] = 1'b1;
          wd_c[cpu_ex_pkg::FLAG_U] = 1'b1;
        end
        use_sp_c = 1'b1;
        sa_c     = stack_pointer;
        stack_pointer_next = stack_pointer - 8'h01;
      end
      cpu_ex_pkg::FN_PLA, cpu_ex_pkg::FN_PLP: begin
        stack_pointer_next = stack_pointer + 8'h01;
        use_sp_c = 1'b1;
        sa_c     = stack_pointer + 8'h01;
        if (func == cpu_ex_pkg::FN_PLA) begin
          accumulator_next  = operand;
          status_flags_next = with_nz(status_flags, operand);
        end else begin
          status_flags_next = operand;
          status_flags_next[cpu_ex_pkg::FLAG_B] = 1'b0;
          status_flags_next[cpu_ex_pkg::FLAG_U] = 1'b1;
        end
      end
      cpu_ex_pkg::FN_BCC, cpu_ex_pkg::FN_BCS, cpu_ex_pkg::FN_BEQ, cpu_ex_pkg::FN_BNE,
      cpu_ex_pkg::FN_BMI, cpu_ex_pkg::FN_BPL, cpu_ex_pkg::FN_BVC, cpu_ex_pkg::FN_BVS: begin
        target_c = target_sum;
        if (branch_flag == branch_want) begin
          taken_c   = 1'b1;
          crossed_c = (target_sum[15:8] != next_pc[15:8]);
        end
      end
      default: ;
    endcase
  end

  // Commit state on acceptance; hold the result until the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= 8'h00;
      index_x       <= 8'h00;
      index_y       <= 8'h00;
      stack_pointer <= cpu_ex_pkg::SP_RESET;
      status_flags  <= cpu_ex_pkg::FLAGS_RESET;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        accumulator   <= accumulator_next;
        index_x       <= index_x_next;
        index_y       <= index_y_next;
        stack_pointer <= stack_pointer_next;
        status_flags  <= status_flags_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      write_enable      <= we_c;
      write_data        <= wd_c;
      use_stack_address <= use_sp_c;
      stack_address     <= sa_c;
      branch_taken      <= taken_c;
      branch_target     <= target_c;
      page_crossed      <= crossed_c;
      flags_out         <= status_flags_next;
      accumulator_out   <= accumulator_next;
    end
  end

endmodule
